[rtl/dwa_pkg.sv]
// ----------------------------------------------------------------------------
// dwa_pkg
// Shared constants, status codes and control types of the dual-wavelength
// absorbance pipeline.
// ----------------------------------------------------------------------------
package dwa_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int IN_FIELD_W = 16;
    localparam int NUM_FIELDS = 6;
    localparam int IN_DATA_W  = IN_FIELD_W * NUM_FIELDS;

    localparam int WORK_FRAC  = 36;
    localparam int LOG_FRAC   = 30;
    localparam int MANT_W     = LOG_FRAC + 1;
    localparam int P_W        = 5;
    localparam int LOG_W      = LOG_FRAC + P_W;
    localparam int NUM_LOGS   = 4;

    localparam int L10_W      = 27;
    localparam logic [L10_W-1:0] LOG10_2_Q28 = 27'd80807124;
    localparam int L10_SHIFT  = LOG_FRAC + 28 - WORK_FRAC;

    localparam int OUT_W      = 34;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int STATUS_W   = 2;

    // Log lanes.
    localparam int LG_NA = 0;
    localparam int LG_DA = 1;
    localparam int LG_NB = 2;
    localparam int LG_DB = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_MAIN_NONPOS = 2'd1,
        ST_ZERO_DEN    = 2'd2,
        ST_BASE_NONPOS = 2'd3
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } ctl_t;

endpackage

[rtl/dwa_prep.sv]
// ----------------------------------------------------------------------------
// dwa_prep
// Entry stage: pixel differences, case decode, divider operand choice and
// log mantissa normalization.
// ----------------------------------------------------------------------------
module dwa_prep #(
    parameter int COUNT_BITS = dwa_pkg::COUNT_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [dwa_pkg::IN_DATA_W-1:0]               in_data,
    output dwa_pkg::ctl_t                               ctl,
    output logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::P_W-1:0]    pos,
    output logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::MANT_W-1:0] mant,
    output logic [COUNT_BITS+dwa_pkg::WORK_FRAC-1:0]    num,
    output logic [COUNT_BITS-1:0]                       den
);
    import dwa_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int QB = CB + WORK_FRAC;

    logic [CB-1:0]  ra, dka, sa, rb, dkb, sb;
    logic [CB:0]    na, da, nb, db;
    logic [CB-1:0]  mag [NUM_LOGS];
    logic           main_nonpos;
    status_t        status_c;

    ctl_t                                ctl_reg, ctl_next;
    logic [NUM_LOGS-1:0][P_W-1:0]        pos_reg, pos_next;
    logic [NUM_LOGS-1:0][MANT_W-1:0]     mant_reg, mant_next;
    logic [QB-1:0]                       num_reg, num_next;
    logic [CB-1:0]                       den_reg, den_next;

    // Each count field is cut down to, or zero-extended to, COUNT_BITS bits.
    assign ra  = CB'(in_data[0*IN_FIELD_W +: IN_FIELD_W]);
    assign dka = CB'(in_data[1*IN_FIELD_W +: IN_FIELD_W]);
    assign sa  = CB'(in_data[2*IN_FIELD_W +: IN_FIELD_W]);
    assign rb  = CB'(in_data[3*IN_FIELD_W +: IN_FIELD_W]);
    assign dkb = CB'(in_data[4*IN_FIELD_W +: IN_FIELD_W]);
    assign sb  = CB'(in_data[5*IN_FIELD_W +: IN_FIELD_W]);

    assign na = {1'b0, ra} - {1'b0, dka};
    assign da = {1'b0, sa} - {1'b0, dka};
    assign nb = {1'b0, rb} - {1'b0, dkb};
    assign db = {1'b0, sb} - {1'b0, dkb};

    assign mag[LG_NA] = na[CB] ? CB'(-na) : na[CB-1:0];
    assign mag[LG_DA] = da[CB] ? CB'(-da) : da[CB-1:0];
    assign mag[LG_NB] = nb[CB] ? CB'(-nb) : nb[CB-1:0];
    assign mag[LG_DB] = db[CB] ? CB'(-db) : db[CB-1:0];

    assign main_nonpos = (na == '0) || (na[CB] != da[CB]);

    always_comb
    begin
        if (da == '0)
        begin
            status_c = ST_ZERO_DEN;
        end
        else if (main_nonpos)
        begin
            status_c = ST_MAIN_NONPOS;
        end
        else if (db == '0)
        begin
            status_c = ST_ZERO_DEN;
        end
        else if ((nb == '0) || (nb[CB] != db[CB]))
        begin
            status_c = ST_BASE_NONPOS;
        end
        else
        begin
            status_c = ST_OK;
        end
    end

    // Normalize each magnitude so that its leading one sits at bit LOG_FRAC.
    always_comb
    begin
        logic [P_W-1:0] p;
        for (int j = 0; j < NUM_LOGS; j++)
        begin
            p = '0;
            for (int i = 0; i < CB; i++)
            begin
                if (mag[j][i])
                begin
                    p = P_W'(i);
                end
            end
            pos_next[j]  = p;
            mant_next[j] = MANT_W'(mag[j]) << (P_W'(LOG_FRAC) - p);
        end
    end

    assign ctl_next = '{valid: in_valid, status: status_c};
    assign num_next = main_nonpos ? {mag[LG_NA], {WORK_FRAC{1'b0}}}
                                  : {mag[LG_NB], {WORK_FRAC{1'b0}}};
    assign den_next = main_nonpos ? mag[LG_DA] : mag[LG_DB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, status: ST_OK};
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg  <= pos_next;
            mant_reg <= mant_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

    assign ctl  = ctl_reg;
    assign pos  = pos_reg;
    assign mant = mant_reg;
    assign num  = num_reg;
    assign den  = den_reg;

endmodule

[rtl/dwa_cell.sv]
// ----------------------------------------------------------------------------
// dwa_cell
// One link of the chain: one restoring division step and, in the first
// LOG_FRAC links, one squaring step of each of the four log2 mantissas.
// ----------------------------------------------------------------------------
module dwa_cell #(
    parameter int COUNT_BITS = dwa_pkg::COUNT_BITS_DEF,
    parameter bit DO_LOG     = 1'b1
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  dwa_pkg::ctl_t                                   ctl_in,
    input  logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::P_W-1:0]      pos_in,
    input  logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::MANT_W-1:0]   mant_in,
    input  logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::LOG_FRAC-1:0] frac_in,
    input  logic [COUNT_BITS-1:0]                           rem_in,
    input  logic [COUNT_BITS-1:0]                           den_in,
    input  logic [COUNT_BITS+dwa_pkg::WORK_FRAC-1:0]        num_in,
    input  logic [COUNT_BITS+dwa_pkg::WORK_FRAC-1:0]        quo_in,
    output dwa_pkg::ctl_t                                   ctl_out,
    output logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::P_W-1:0]      pos_out,
    output logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::MANT_W-1:0]   mant_out,
    output logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::LOG_FRAC-1:0] frac_out,
    output logic [COUNT_BITS-1:0]                           rem_out,
    output logic [COUNT_BITS-1:0]                           den_out,
    output logic [COUNT_BITS+dwa_pkg::WORK_FRAC-1:0]        num_out,
    output logic [COUNT_BITS+dwa_pkg::WORK_FRAC-1:0]        quo_out
);
    import dwa_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int QB = CB + WORK_FRAC;

    logic [CB:0]    trial, diff;
    logic           fits;

    ctl_t                                 ctl_reg;
    logic [NUM_LOGS-1:0][P_W-1:0]         pos_reg;
    logic [NUM_LOGS-1:0][MANT_W-1:0]      mant_reg, mant_next;
    logic [NUM_LOGS-1:0][LOG_FRAC-1:0]    frac_reg, frac_next;
    logic [CB-1:0]                        rem_reg, rem_next;
    logic [CB-1:0]                        den_reg;
    logic [QB-1:0]                        num_reg, num_next;
    logic [QB-1:0]                        quo_reg, quo_next;

    // Restoring division: bring down the next numerator bit.
    assign trial    = {rem_in, num_in[QB-1]};
    assign fits     = (trial >= {1'b0, den_in});
    assign diff     = trial - {1'b0, den_in};
    assign rem_next = fits ? diff[CB-1:0] : trial[CB-1:0];
    assign num_next = {num_in[QB-2:0], 1'b0};
    assign quo_next = {quo_in[QB-2:0], fits};

    genvar j;
    generate
        for (j = 0; j < NUM_LOGS; j++)
        begin : g_lane
            if (DO_LOG)
            begin : g_sq
                logic [2*MANT_W-1:0] sq;
                logic [MANT_W:0]     top;
                assign sq  = (2*MANT_W)'(mant_in[j]) * (2*MANT_W)'(mant_in[j]);
                assign top = sq[LOG_FRAC +: MANT_W+1];
                // A square of 2 or more yields a one in the fraction.
                assign mant_next[j] = top[MANT_W] ? top[MANT_W:1] : top[MANT_W-1:0];
                assign frac_next[j] = {frac_in[j][LOG_FRAC-2:0], top[MANT_W]};
            end
            else
            begin : g_pass
                assign mant_next[j] = mant_in[j];
                assign frac_next[j] = frac_in[j];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, status: ST_OK};
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg  <= pos_in;
            mant_reg <= mant_next;
            frac_reg <= frac_next;
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            num_reg  <= num_next;
            quo_reg  <= quo_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign pos_out  = pos_reg;
    assign mant_out = mant_reg;
    assign frac_out = frac_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign num_out  = num_reg;
    assign quo_out  = quo_reg;

endmodule

[rtl/dwa_post.sv]
// ----------------------------------------------------------------------------
// dwa_post
// Tail stages: log2 difference, scaling to log10, case merge, rounding
// and saturation to the signed output format.
// ----------------------------------------------------------------------------
module dwa_post #(
    parameter int COUNT_BITS = dwa_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = dwa_pkg::FRAC_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  dwa_pkg::ctl_t                                   ctl_in,
    input  logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::P_W-1:0]      pos_in,
    input  logic [dwa_pkg::NUM_LOGS-1:0][dwa_pkg::LOG_FRAC-1:0] frac_in,
    input  logic [COUNT_BITS+dwa_pkg::WORK_FRAC-1:0]        quo_in,
    output dwa_pkg::ctl_t                                   ctl_out,
    output logic [dwa_pkg::OUT_W-1:0]                       absorbance
);
    import dwa_pkg::*;

    localparam int QB    = COUNT_BITS + WORK_FRAC;
    localparam int DW    = LOG_W + 2;
    localparam int MW    = LOG_W + 1;
    localparam int V_W   = MW + L10_W - L10_SHIFT;
    localparam int WK_W  = QB + 2;
    localparam int SH    = WORK_FRAC - FRAC_BITS;
    localparam logic [WK_W-1:0] HALF = WK_W'(1) << (SH - 1);
    localparam logic [WK_W-1:0] LIM  = WK_W'(1) << (OUT_W - 1);

    // Stage A: log2 difference.
    logic [DW-1:0]  main_d, base_d, d2;
    logic [LOG_W-1:0] lg [NUM_LOGS];
    ctl_t           a_ctl_reg;
    logic [MW-1:0]  a_mag_reg, a_mag_next;
    logic           a_neg_reg;
    logic [QB-1:0]  a_quo_reg;

    // Stage B: scaling by log10(2).
    logic [MW+L10_W-1:0] prod;
    ctl_t           b_ctl_reg;
    logic [V_W-1:0] b_v_reg;
    logic           b_neg_reg;
    logic [QB-1:0]  b_quo_reg;

    // Stage C: merge, round, saturate.
    logic [WK_W-1:0] sv, work, wmag, rnd, lim_mag, res;
    logic            wneg;
    ctl_t            c_ctl_reg;
    logic [OUT_W-1:0] c_abs_reg, c_abs_next;

    always_comb
    begin
        for (int j = 0; j < NUM_LOGS; j++)
        begin
            lg[j] = {pos_in[j], frac_in[j]};
        end
    end

    assign main_d = DW'(lg[LG_NA]) - DW'(lg[LG_DA]);
    assign base_d = DW'(lg[LG_NB]) - DW'(lg[LG_DB]);
    assign d2     = (ctl_in.status == ST_OK) ? main_d - base_d : main_d;
    assign a_mag_next = d2[DW-1] ? MW'(-d2) : d2[MW-1:0];

    assign prod = (MW+L10_W)'(a_mag_reg) * (MW+L10_W)'(LOG10_2_Q28);

    assign sv = b_neg_reg ? -WK_W'(b_v_reg) : WK_W'(b_v_reg);

    always_comb
    begin
        case (b_ctl_reg.status)
            ST_OK:          work = sv;
            ST_MAIN_NONPOS: work = -WK_W'(b_quo_reg);
            ST_ZERO_DEN:    work = '0;
            ST_BASE_NONPOS: work = sv + WK_W'(b_quo_reg);
            default:        work = '0;
        endcase
    end

    assign wneg    = work[WK_W-1];
    assign wmag    = wneg ? -work : work;
    assign rnd     = (wmag + HALF) >> SH;
    assign lim_mag = wneg ? ((rnd > LIM) ? LIM : rnd)
                          : ((rnd > LIM - WK_W'(1)) ? LIM - WK_W'(1) : rnd);
    assign res     = wneg ? -lim_mag : lim_mag;
    assign c_abs_next = res[OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '{valid: 1'b0, status: ST_OK};
            b_ctl_reg <= '{valid: 1'b0, status: ST_OK};
            c_ctl_reg <= '{valid: 1'b0, status: ST_OK};
        end
        else if (en)
        begin
            a_ctl_reg <= ctl_in;
            b_ctl_reg <= a_ctl_reg;
            c_ctl_reg <= b_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg <= a_mag_next;
            a_neg_reg <= d2[DW-1];
            a_quo_reg <= quo_in;
            b_v_reg   <= prod[L10_SHIFT +: V_W];
            b_neg_reg <= a_neg_reg;
            b_quo_reg <= a_quo_reg;
            c_abs_reg <= c_abs_next;
        end
    end

    assign ctl_out    = c_ctl_reg;
    assign absorbance = c_abs_reg;

endmodule

[rtl/dual_wavelength_absorbance.sv]
// ----------------------------------------------------------------------------
// dual_wavelength_absorbance
// Baseline-corrected absorbance from dark-corrected counts at an absorbing
// and a non-absorbing pixel, as a streaming pipeline.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  s_tdata: six 16-bit pixel counts
//  m_*      out  m_tvalid/m_tready  m_tdata: absorbance, m_tuser: status
//
// One transaction is taken per cycle while the skid register is empty. The
// pipeline is a chain of division cells, one quotient bit per cell, which
// also carries the squaring steps of the four log2 mantissas. Reset clears
// only the valid bits, so the block is ready as soon as reset is released.
// When the output register holds a result, m_tready is low and a new result
// reaches the output, it parks in a skid register and the whole pipeline,
// including s_tready, holds until the skid register empties.
// ----------------------------------------------------------------------------
module dual_wavelength_absorbance #(
    parameter int COUNT_BITS = dwa_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = dwa_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ref_absorbing, dark_absorbing, sample_absorbing,
    // ref_baseline, dark_baseline, sample_baseline (16 bits each)
    input  logic [dwa_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // absorbance (34 bits, signed), zero padding
    output logic [dwa_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status (2 bits)
    output logic [dwa_pkg::STATUS_W-1:0]    m_tuser
);
    import dwa_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int QB = CB + WORK_FRAC;

    logic en;
    logic in_acc;

    // Signals between the links of the chain; index 0 is the entry stage.
    ctl_t                               ctl_c  [0:QB];
    logic [NUM_LOGS-1:0][P_W-1:0]       pos_c  [0:QB];
    logic [NUM_LOGS-1:0][MANT_W-1:0]    mant_c [0:QB];
    logic [NUM_LOGS-1:0][LOG_FRAC-1:0]  frac_c [0:QB];
    logic [CB-1:0]                      rem_c  [0:QB];
    logic [CB-1:0]                      den_c  [0:QB];
    logic [QB-1:0]                      num_c  [0:QB];
    logic [QB-1:0]                      quo_c  [0:QB];

    ctl_t             post_ctl;
    logic [OUT_W-1:0] post_abs;

    // Output register and skid register.
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_abs_reg;
    status_t          out_status_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] skid_abs_reg;
    status_t          skid_status_reg;

    // The pipeline moves whenever the skid register is empty.
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign in_acc   = s_tvalid && s_tready;

    dwa_prep #(
        .COUNT_BITS (COUNT_BITS)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_acc),
        .in_data  (s_tdata),
        .ctl      (ctl_c[0]),
        .pos      (pos_c[0]),
        .mant     (mant_c[0]),
        .num      (num_c[0]),
        .den      (den_c[0])
    );

    // The fraction, remainder and quotient start at zero in the first cell.
    assign frac_c[0] = '0;
    assign rem_c[0]  = '0;
    assign quo_c[0]  = '0;

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_chain
            dwa_cell #(
                .COUNT_BITS (COUNT_BITS),
                .DO_LOG     (k < LOG_FRAC)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .ctl_in   (ctl_c[k]),
                .pos_in   (pos_c[k]),
                .mant_in  (mant_c[k]),
                .frac_in  (frac_c[k]),
                .rem_in   (rem_c[k]),
                .den_in   (den_c[k]),
                .num_in   (num_c[k]),
                .quo_in   (quo_c[k]),
                .ctl_out  (ctl_c[k+1]),
                .pos_out  (pos_c[k+1]),
                .mant_out (mant_c[k+1]),
                .frac_out (frac_c[k+1]),
                .rem_out  (rem_c[k+1]),
                .den_out  (den_c[k+1]),
                .num_out  (num_c[k+1]),
                .quo_out  (quo_c[k+1])
            );
        end
    endgenerate

    dwa_post #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl_in     (ctl_c[QB]),
        .pos_in     (pos_c[QB]),
        .frac_in    (frac_c[QB]),
        .quo_in     (quo_c[QB]),
        .ctl_out    (post_ctl),
        .absorbance (post_abs)
    );

    // A result leaving the last stage goes to the output register when that
    // is free or being drained this cycle, otherwise to the skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (post_ctl.valid)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_abs_reg    <= skid_abs_reg;
                out_status_reg <= skid_status_reg;
            end
        end
        else if (post_ctl.valid)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_abs_reg    <= post_abs;
                out_status_reg <= post_ctl.status;
            end
            else
            begin
                skid_abs_reg    <= post_abs;
                skid_status_reg <= post_ctl.status;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_abs_reg);
    assign m_tuser  = out_status_reg;

    // The skid register only fills behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    // A stalled full skid keeps the pipeline frozen on the next cycle too.
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && !s_tready))
        else $error("skid register lost a result under stall");

    // A zero denominator always yields a zero absorbance.
    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_ZERO_DEN)) |-> (m_tdata[OUT_W-1:0] == '0))
        else $error("zero denominator result is not zero");

    // A non-positive main ratio is passed on with its sign.
    a_main_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_MAIN_NONPOS))
            |-> (m_tdata[OUT_W-1] || (m_tdata[OUT_W-1:0] == '0)))
        else $error("non-positive main ratio came out positive");

endmodule

[verif/tb_dual_wavelength_absorbance.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_wavelength_absorbance
// Streams pixel count sets into the absorbance pipeline with random idling on
// both sides and compares every result against a local bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_dual_wavelength_absorbance;

    import dwa_pkg::*;

    localparam int OUT_LIM_W = OUT_W;

    typedef struct packed {
        logic [15:0] sb;
        logic [15:0] db;
        logic [15:0] rb;
        logic [15:0] sa;
        logic [15:0] da;
        logic [15:0] ra;
    } counts_t;

    typedef struct {
        logic [OUT_W-1:0] absorbance;
        status_t          status;
    } absorb_result_t;

    // Log2 of a positive count in Q.30, by repeated squaring of the mantissa.
    function automatic longint log2_q30(longint unsigned x);
        int p;
        longint unsigned t;
        longint unsigned m;
        longint unsigned r;
        p = 0;
        t = x;
        if (x == 0)
            return 0;
        while (t > 1)
        begin
            t = t >> 1;
            p++;
        end
        m = x << (LOG_FRAC - p);
        r = longint'(p) << LOG_FRAC;
        for (int i = LOG_FRAC - 1; i >= 0; i--)
        begin
            m = (m * m) >> LOG_FRAC;
            if (m >= (64'd1 << (LOG_FRAC + 1)))
            begin
                m = m >> 1;
                r = r | (64'd1 << i);
            end
        end
        return longint'(r);
    endfunction

    function automatic longint log10_q36(longint d2);
        longint unsigned mag;
        longint unsigned v;
        mag = (d2 < 0) ? longint'(-d2) : d2;
        v = (mag * 64'd80807124) >> (LOG_FRAC + 28 - WORK_FRAC);
        return (d2 < 0) ? -longint'(v) : longint'(v);
    endfunction

    function automatic longint unsigned ratio_q36(longint unsigned n, longint unsigned d);
        if (d == 0)
            return 0;
        return (n << WORK_FRAC) / d;
    endfunction

    function automatic logic [OUT_W-1:0] round_saturate(longint v);
        longint unsigned mag;
        longint unsigned r;
        longint unsigned lim;
        mag = (v < 0) ? longint'(-v) : v;
        r = (mag + (64'd1 << (WORK_FRAC - FRAC_BITS_DEF - 1))) >> (WORK_FRAC - FRAC_BITS_DEF);
        lim = 64'd1 << (OUT_LIM_W - 1);
        if (v >= 0 && r > lim - 1)
            r = lim - 1;
        if (v < 0 && r > lim)
            r = lim;
        if (v < 0)
            r = -r;
        return r[OUT_W-1:0];
    endfunction

    function automatic absorb_result_t predict_absorbance(counts_t c);
        absorb_result_t res;
        longint na, da, nb, db, w;
        longint unsigned mna, mda, mnb, mdb;
        na = longint'(c.ra) - longint'(c.da);
        da = longint'(c.sa) - longint'(c.da);
        nb = longint'(c.rb) - longint'(c.db);
        db = longint'(c.sb) - longint'(c.db);
        mna = (na < 0) ? -na : na;
        mda = (da < 0) ? -da : da;
        mnb = (nb < 0) ? -nb : nb;
        mdb = (db < 0) ? -db : db;
        if (da == 0)
        begin
            w = 0;
            res.status = ST_ZERO_DEN;
        end
        else if (na == 0 || ((na < 0) != (da < 0)))
        begin
            w = -longint'(ratio_q36(mna, mda));
            res.status = ST_MAIN_NONPOS;
        end
        else if (db == 0)
        begin
            w = 0;
            res.status = ST_ZERO_DEN;
        end
        else if (nb == 0 || ((nb < 0) != (db < 0)))
        begin
            w = log10_q36(log2_q30(mna) - log2_q30(mda)) + longint'(ratio_q36(mnb, mdb));
            res.status = ST_BASE_NONPOS;
        end
        else
        begin
            w = log10_q36((log2_q30(mna) - log2_q30(mda)) - (log2_q30(mnb) - log2_q30(mdb)));
            res.status = ST_OK;
        end
        res.absorbance = round_saturate(w);
        return res;
    endfunction

    class absorbance_scoreboard;
        absorb_result_t pending[$];
        int             mismatches;

        function void note_counts(counts_t c);
            pending.push_back(predict_absorbance(c));
        endfunction

        function void check_result(logic [OUT_W-1:0] absorbance, logic [STATUS_W-1:0] status);
            absorb_result_t exp_res;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: absorbance %h status %0d", absorbance, status);
                return;
            end
            exp_res = pending.pop_front();
            if (absorbance !== exp_res.absorbance || status !== exp_res.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result mismatch: expected %h/%0d, got %h/%0d",
                             exp_res.absorbance, exp_res.status, absorbance, status);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // ref_absorbing, dark_absorbing, sample_absorbing,
    // ref_baseline, dark_baseline, sample_baseline
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // absorbance, zero padding
    logic [OUT_DATA_W-1:0] m_tdata;
    // status
    logic [STATUS_W-1:0]   m_tuser;

    absorbance_scoreboard  board;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    bit                    stream_done;

    always #2 clk = ~clk;

    dual_wavelength_absorbance i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The receiver draws its ready at every edge and checks each accepted
    // result transaction against the oldest predicted one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[OUT_W-1:0], m_tuser);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one count set and holds it until the transaction completes. An
    // idle gap is inserted before the item at the current sender idle rate.
    task automatic send_counts(counts_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_counts(c);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // A random count; often one of the edge values so that equal counts,
    // zero differences and full-scale differences show up often.
    function automatic logic [15:0] pick_count();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic counts_t random_counts();
        counts_t c;
        logic [15:0] d;
        d = pick_count();
        c.ra = pick_count();
        c.sa = pick_count();
        c.rb = pick_count();
        c.sb = pick_count();
        c.da = d;
        c.db = pick_count();
        // Mostly a well-formed measurement: reference above sample above dark.
        if ($urandom_range(99) < 70)
        begin
            c.da = 16'($urandom_range(4000));
            c.sa = c.da + 16'($urandom_range(20000)) + 16'd1;
            c.ra = c.sa + 16'($urandom_range(30000));
            c.db = 16'($urandom_range(4000));
            c.sb = c.db + 16'($urandom_range(20000)) + 16'd1;
            c.rb = c.sb + 16'($urandom_range(30000));
            if ($urandom_range(9) == 0)
                c.rb = c.db - 16'($urandom_range(c.db));
        end
        return c;
    endfunction

    task automatic send_directed();
        counts_t list[$];
        list.push_back('{sb:16'd1, db:16'd0, rb:16'd100, sa:16'd50, da:16'd10, ra:16'd500});
        list.push_back('{sb:16'd10, db:16'd0, rb:16'd10, sa:16'd10, da:16'd0, ra:16'd10});
        list.push_back('{sb:16'd1, db:16'd0, rb:16'd65535, sa:16'd1, da:16'd0, ra:16'd65535});
        list.push_back('{sb:16'd65535, db:16'd0, rb:16'd1, sa:16'd65535, da:16'd0, ra:16'd1});
        // Zero main denominator.
        list.push_back('{sb:16'd9, db:16'd1, rb:16'd40, sa:16'd7, da:16'd7, ra:16'd90});
        // Main numerator zero, main ratio of the wrong sign, and a zero baseline denominator.
        list.push_back('{sb:16'd9, db:16'd1, rb:16'd40, sa:16'd70, da:16'd7, ra:16'd7});
        list.push_back('{sb:16'd9, db:16'd1, rb:16'd40, sa:16'd70, da:16'd7, ra:16'd0});
        list.push_back('{sb:16'd0, db:16'd0, rb:16'd0, sa:16'd1, da:16'd65535, ra:16'd0});
        list.push_back('{sb:16'd0, db:16'd0, rb:16'd0, sa:16'd0, da:16'd65534, ra:16'd65535});
        // Zero baseline denominator with a positive main ratio.
        list.push_back('{sb:16'd5, db:16'd5, rb:16'd40, sa:16'd70, da:16'd7, ra:16'd700});
        // Baseline numerator zero, and baseline of the wrong sign.
        list.push_back('{sb:16'd50, db:16'd5, rb:16'd5, sa:16'd70, da:16'd7, ra:16'd700});
        list.push_back('{sb:16'd50, db:16'd5, rb:16'd0, sa:16'd70, da:16'd7, ra:16'd700});
        list.push_back('{sb:16'd1, db:16'd65535, rb:16'd65535, sa:16'd2, da:16'd0, ra:16'd65535});
        // Both differences negative give positive ratios.
        list.push_back('{sb:16'd10, db:16'd900, rb:16'd100, sa:16'd400, da:16'd500, ra:16'd20});
        list.push_back('{sb:16'hFFFF, db:16'hFFFF, rb:16'hFFFF, sa:16'hFFFF, da:16'hFFFF,
                         ra:16'hFFFF});
        list.push_back('0);
        list.push_back('{sb:16'hAAAA, db:16'h5555, rb:16'hFFFF, sa:16'h5556, da:16'h5555,
                         ra:16'hAAAA});
        foreach (list[i])
            send_counts(list[i]);
    endtask

    initial
    begin
        board = new();
        send_idle_pct = 35;
        recv_idle_pct = 62;
        stream_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        // Hold off until the pipeline has drained everything sent so far.
        go_idle();
        while (board.pending.size() != 0)
            @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 35 : 0;
            for (int n = 0; n < 150; n++)
                send_counts(random_counts());
        end
        go_idle();

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        if (board.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a stalled handshake.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[dual_wavelength_absorbance.f]
rtl/dwa_pkg.sv
rtl/dwa_prep.sv
rtl/dwa_cell.sv
rtl/dwa_post.sv
rtl/dual_wavelength_absorbance.sv
verif/tb_dual_wavelength_absorbance.sv
